// ----- rtl/atpr_pkg.sv -----
// atpr_pkg: shared constants, control struct and arctangent table for the
// tilt angle pipeline. Used by every file in rtl.
package atpr_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 9;
  localparam int TAB_FRAC        = 20;
  localparam int STAGES          = 24;
  localparam int ANGLE_SHIFT     = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam int SQ_W            = 2 * SAMPLE_WIDTH;
  localparam int SUM_W           = SQ_W + 1;
  localparam int ABS_W           = SAMPLE_WIDTH + 1;
  localparam int NORM_W          = 62;
  localparam int ROOT_STEPS      = 31;
  localparam int ROOT_W          = 31;
  localparam int Y_W             = 32;
  localparam int CX_W            = 36;
  localparam int Z_W             = 30;
  localparam int K_W             = 6;
  localparam int S_LIMIT_LOG2    = 60;
  localparam int Y_LIMIT_LOG2    = 30;
  localparam int HALF_TURN       = 180 << ANGLE_FRAC_BITS;
  localparam int FRONT_STAGES    = 5;
  localparam int LATENCY         = FRONT_STAGES + ROOT_STEPS + STAGES + 2;

  typedef struct packed {
    logic valid;
    logic zero;
    logic num_pos;
    logic zneg;
  } ctl_t;

  function automatic logic signed [Z_W-1:0] atan_tab(input int i);
    logic signed [Z_W-1:0] t;
    case (i)
      0:  t = 30'sd47185920;
      1:  t = 30'sd27855475;
      2:  t = 30'sd14718068;
      3:  t = 30'sd7471121;
      4:  t = 30'sd3750058;
      5:  t = 30'sd1876857;
      6:  t = 30'sd938658;
      7:  t = 30'sd469357;
      8:  t = 30'sd234682;
      9:  t = 30'sd117342;
      10: t = 30'sd58671;
      11: t = 30'sd29335;
      12: t = 30'sd14668;
      13: t = 30'sd7334;
      14: t = 30'sd3667;
      15: t = 30'sd1833;
      16: t = 30'sd917;
      17: t = 30'sd458;
      18: t = 30'sd229;
      19: t = 30'sd115;
      20: t = 30'sd57;
      21: t = 30'sd29;
      22: t = 30'sd14;
      23: t = 30'sd7;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/atpr_sqrt.sv -----
// atpr_sqrt: pipelined floor square root, one result bit per stage.
// Depends on atpr_pkg; carries the numerator and control alongside.
module atpr_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [atpr_pkg::NORM_W-1:0]       rad,
  input  logic signed [atpr_pkg::Y_W-1:0]   y_in,
  input  atpr_pkg::ctl_t                    ctl_in,
  output logic [atpr_pkg::ROOT_W-1:0]       root,
  output logic signed [atpr_pkg::Y_W-1:0]   y_out,
  output atpr_pkg::ctl_t                    ctl_out
);

  localparam int N = atpr_pkg::ROOT_STEPS;
  localparam int W = atpr_pkg::NORM_W + 1;

  logic [W-1:0]                    v_q [0:N];
  logic [W-1:0]                    r_q [0:N];
  logic signed [atpr_pkg::Y_W-1:0] y_q [0:N];
  atpr_pkg::ctl_t                  c_q [0:N];

  assign v_q[0] = {1'b0, rad};
  assign r_q[0] = '0;
  assign y_q[0] = y_in;
  assign c_q[0] = ctl_in;

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int POS = 2 * (N - 1 - j);
    logic [W-1:0] bitv;
    logic [W-1:0] trial;
    always_comb begin
      bitv  = W'(1) << POS;
      trial = r_q[j] + bitv;
    end
    always_ff @(posedge clk) begin
      if (v_q[j] >= trial) begin
        v_q[j+1] <= v_q[j] - trial;
        r_q[j+1] <= (r_q[j] >> 1) + bitv;
      end else begin
        v_q[j+1] <= v_q[j];
        r_q[j+1] <= r_q[j] >> 1;
      end
      y_q[j+1] <= y_q[j];
      c_q[j+1] <= c_q[j];
      if (rst) begin
        c_q[j+1].valid <= 1'b0;
      end
    end
  end

  assign root    = r_q[N][atpr_pkg::ROOT_W-1:0];
  assign y_out   = y_q[N];
  assign ctl_out = c_q[N];

endmodule

// ----- rtl/atpr_cordic.sv -----
// atpr_cordic: vectoring cordic, one registered stage per iteration.
// Depends on atpr_pkg for widths and the arctangent table.
module atpr_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [atpr_pkg::ROOT_W-1:0]       x_in,
  input  logic signed [atpr_pkg::Y_W-1:0]   y_in,
  input  atpr_pkg::ctl_t                    ctl_in,
  output logic signed [atpr_pkg::Z_W-1:0]   z_out,
  output atpr_pkg::ctl_t                    ctl_out
);

  localparam int N  = atpr_pkg::STAGES;
  localparam int XW = atpr_pkg::CX_W;

  logic signed [XW-1:0]            x_q [0:N];
  logic signed [XW-1:0]            y_q [0:N];
  logic signed [atpr_pkg::Z_W-1:0] z_q [0:N];
  atpr_pkg::ctl_t                  c_q [0:N];

  assign x_q[0] = signed'({{(XW-atpr_pkg::ROOT_W){1'b0}}, x_in});
  assign y_q[0] = XW'(y_in);
  assign z_q[0] = '0;
  assign c_q[0] = ctl_in;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    always_comb begin
      dx = y_q[i] >>> i;
      dy = x_q[i] >>> i;
    end
    always_ff @(posedge clk) begin
      if (!y_q[i][XW-1]) begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + atpr_pkg::atan_tab(i);
      end else begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - atpr_pkg::atan_tab(i);
      end
      c_q[i+1] <= c_q[i];
      if (rst) begin
        c_q[i+1].valid <= 1'b0;
      end
    end
  end

  assign z_out   = z_q[N];
  assign ctl_out = c_q[N];

endmodule

// ----- rtl/atpr_tilt.sv -----
// atpr_tilt: one tilt angle atan2(n, sqrt(a^2 + b^2)) before folding.
// Depends on atpr_pkg, atpr_sqrt and atpr_cordic.
module atpr_tilt (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic signed [atpr_pkg::SAMPLE_WIDTH-1:0] num,
  input  logic signed [atpr_pkg::SAMPLE_WIDTH-1:0] den_a,
  input  logic signed [atpr_pkg::SAMPLE_WIDTH-1:0] den_b,
  input  atpr_pkg::ctl_t                           ctl_in,
  output logic signed [atpr_pkg::ANGLE_WIDTH-1:0]  angle,
  output atpr_pkg::ctl_t                           ctl_out
);

  localparam int SW = atpr_pkg::SAMPLE_WIDTH;
  localparam int KW = atpr_pkg::K_W;

  // squares
  logic [atpr_pkg::SQ_W-1:0] a2;
  logic [atpr_pkg::SQ_W-1:0] b2;
  logic signed [SW-1:0]      n_a;
  atpr_pkg::ctl_t            c_a;

  always_ff @(posedge clk) begin
    a2  <= atpr_pkg::SQ_W'(den_a * den_a);
    b2  <= atpr_pkg::SQ_W'(den_b * den_b);
    n_a <= num;
    c_a <= ctl_in;
    c_a.zero    <= (num == '0);
    c_a.num_pos <= !num[SW-1] && (num != '0);
    if (rst) begin
      c_a.valid <= 1'b0;
    end
  end

  // sum and magnitude of numerator
  logic [atpr_pkg::SUM_W-1:0] s_b;
  logic [atpr_pkg::ABS_W-1:0] na_b;
  logic signed [SW-1:0]       n_b;
  atpr_pkg::ctl_t             c_b;

  always_ff @(posedge clk) begin
    s_b  <= {1'b0, a2} + {1'b0, b2};
    na_b <= n_a[SW-1] ? atpr_pkg::ABS_W'(-{n_a[SW-1], n_a}) : {1'b0, n_a};
    n_b  <= n_a;
    c_b  <= c_a;
    if (rst) begin
      c_b.valid <= 1'b0;
    end
  end

  // normalisation shift count
  logic [KW-1:0] ks;
  logic [KW-1:0] ky;
  int            ps;
  int            py;

  always_comb begin
    ps = -1;
    py = -1;
    for (int i = 0; i < atpr_pkg::SUM_W; i++) begin
      if (s_b[i]) ps = i;
    end
    for (int i = 0; i < atpr_pkg::ABS_W; i++) begin
      if (na_b[i]) py = i;
    end
    ks = (ps < 0) ? '1 : KW'((atpr_pkg::S_LIMIT_LOG2 + 1 - ps) >> 1);
    ky = (py < 0) ? '1 : KW'(atpr_pkg::Y_LIMIT_LOG2 - py);
  end

  logic [KW-1:0]              k_c;
  logic [atpr_pkg::SUM_W-1:0] s_c;
  logic signed [SW-1:0]       n_c;
  atpr_pkg::ctl_t             c_c;

  always_ff @(posedge clk) begin
    k_c <= (ks < ky) ? ks : ky;
    s_c <= s_b;
    n_c <= n_b;
    c_c <= c_b;
    if (rst) begin
      c_c.valid <= 1'b0;
    end
  end

  // apply the shift
  logic [atpr_pkg::NORM_W-1:0]     s_d;
  logic signed [atpr_pkg::Y_W-1:0] y_d;
  atpr_pkg::ctl_t                  c_d;

  always_ff @(posedge clk) begin
    s_d <= atpr_pkg::NORM_W'(s_c) << {k_c, 1'b0};
    y_d <= atpr_pkg::Y_W'(n_c) <<< k_c;
    c_d <= c_c;
    if (rst) begin
      c_d.valid <= 1'b0;
    end
  end

  logic [atpr_pkg::ROOT_W-1:0]     root;
  logic signed [atpr_pkg::Y_W-1:0] y_r;
  atpr_pkg::ctl_t                  c_r;

  atpr_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .rad     (s_d),
    .y_in    (y_d),
    .ctl_in  (c_d),
    .root    (root),
    .y_out   (y_r),
    .ctl_out (c_r)
  );

  logic signed [atpr_pkg::Z_W-1:0] z_k;
  atpr_pkg::ctl_t                  c_k;

  atpr_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .x_in    (root),
    .y_in    (y_r),
    .ctl_in  (c_r),
    .z_out   (z_k),
    .ctl_out (c_k)
  );

  // round to output resolution, halves away from zero
  logic [atpr_pkg::Z_W-1:0] zm;
  logic [atpr_pkg::Z_W-1:0] zr;

  always_comb begin
    zm = z_k[atpr_pkg::Z_W-1] ? atpr_pkg::Z_W'(-z_k) : atpr_pkg::Z_W'(z_k);
    zr = (zm + (atpr_pkg::Z_W'(1) << (atpr_pkg::ANGLE_SHIFT - 1))) >> atpr_pkg::ANGLE_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (c_k.zero) begin
      angle <= '0;
    end else if (z_k[atpr_pkg::Z_W-1]) begin
      angle <= atpr_pkg::ANGLE_WIDTH'(-zr);
    end else begin
      angle <= atpr_pkg::ANGLE_WIDTH'(zr);
    end
    ctl_out <= c_k;
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/accel_tilt_pitch_roll.sv -----
// accel_tilt_pitch_roll: roll and pitch from a three-axis accelerometer sample.
// Depends on atpr_pkg and two atpr_tilt pipelines.
//
// One sample is taken in every clock cycle: busy is always low and start alone
// accepts a request. Results appear with done high for one cycle, in request
// order; the receiver cannot stall them and must take each one as it appears.
// The path runs from the input register through the front end (squares, sum,
// shift search, shift), the 31 stage bit-per-stage square root, the 24 stage
// cordic, rounding and the quadrant fold, each a register stage. Angles are in
// 1/64 degree.
module accel_tilt_pitch_roll (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [atpr_pkg::SAMPLE_WIDTH-1:0] accel_x,
  input  logic signed [atpr_pkg::SAMPLE_WIDTH-1:0] accel_y,
  input  logic signed [atpr_pkg::SAMPLE_WIDTH-1:0] accel_z,
  output logic                                     done,
  output logic signed [atpr_pkg::ANGLE_WIDTH-1:0]  roll_angle,
  output logic signed [atpr_pkg::ANGLE_WIDTH-1:0]  pitch_angle
);

  localparam int AW = atpr_pkg::ANGLE_WIDTH;

  assign busy = 1'b0;

  logic signed [atpr_pkg::SAMPLE_WIDTH-1:0] x_q;
  logic signed [atpr_pkg::SAMPLE_WIDTH-1:0] y_q;
  logic signed [atpr_pkg::SAMPLE_WIDTH-1:0] z_q;
  atpr_pkg::ctl_t                           c_q;

  always_ff @(posedge clk) begin
    x_q <= accel_x;
    y_q <= accel_y;
    z_q <= accel_z;
    c_q.valid   <= start && !busy;
    c_q.zero    <= 1'b0;
    c_q.num_pos <= 1'b0;
    c_q.zneg    <= accel_z[atpr_pkg::SAMPLE_WIDTH-1];
    if (rst) begin
      c_q.valid <= 1'b0;
    end
  end

  logic signed [AW-1:0] roll_raw;
  logic signed [AW-1:0] pitch_raw;
  atpr_pkg::ctl_t       c_roll;
  atpr_pkg::ctl_t       c_pitch;

  atpr_tilt u_roll (
    .clk     (clk),
    .rst     (rst),
    .num     (y_q),
    .den_a   (x_q),
    .den_b   (z_q),
    .ctl_in  (c_q),
    .angle   (roll_raw),
    .ctl_out (c_roll)
  );

  atpr_tilt u_pitch (
    .clk     (clk),
    .rst     (rst),
    .num     (x_q),
    .den_a   (y_q),
    .den_b   (z_q),
    .ctl_in  (c_q),
    .angle   (pitch_raw),
    .ctl_out (c_pitch)
  );

  // fold into +-180 when z is negative
  localparam logic signed [AW:0] HALF = (AW+1)'(atpr_pkg::HALF_TURN);

  logic signed [AW:0] roll_w;
  logic signed [AW:0] pitch_w;
  logic signed [AW:0] roll_f;
  logic signed [AW:0] pitch_f;

  always_comb begin
    roll_w  = {roll_raw[AW-1], roll_raw};
    pitch_w = {pitch_raw[AW-1], pitch_raw};
    roll_f  = roll_w;
    pitch_f = pitch_w;
    if (c_roll.zneg) begin
      roll_f = c_roll.num_pos ? HALF - roll_w : -HALF - roll_w;
    end
    if (c_pitch.zneg) begin
      pitch_f = c_pitch.num_pos ? HALF - pitch_w : -HALF - pitch_w;
    end
  end

  always_ff @(posedge clk) begin
    roll_angle  <= roll_f[AW-1:0];
    pitch_angle <= pitch_f[AW-1:0];
    done        <= c_roll.valid;
    if (rst) begin
      done <= 1'b0;
    end
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(atpr_pkg::LATENCY) done)
    else $error("result missing after request");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, atpr_pkg::LATENCY))
    else $error("result without request");

  a_lanes_aligned : assert property (@(posedge clk) disable iff (rst)
    c_roll.valid == c_pitch.valid)
    else $error("roll and pitch lanes out of step");

endmodule
